@@ src/bucketed_int_hash_set_assert.svh @@
// ----------------------------------------------------------------------------
// bucketed_int_hash_set assertion macros
// Shorthands for clocked, reset-qualified properties on clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef BUCKETED_INT_HASH_SET_ASSERT_SVH
`define BUCKETED_INT_HASH_SET_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BIHS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bihs: same-cycle property failed");

// antecedent implies consequent in the next cycle
`define BIHS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bihs: next-cycle property failed");

`endif

@@ src/bihs_pkg.sv @@
// ----------------------------------------------------------------------------
// bihs_pkg
// Shared types and constants of the bucketed integer hash set.
// ----------------------------------------------------------------------------
package bihs_pkg;

	localparam int KEY_W    = 31;
	localparam int INIT_W   = 9;
	localparam int LIM_W    = 4;
	localparam int LOAD_W   = 12;
	localparam int CFG_W    = 12;
	localparam int CIDX_W   = 2;
	localparam int BOUT_W   = 9;
	localparam int TOT_W    = 12;
	localparam int DCNT_W   = $clog2(KEY_W + 1);

	localparam int INIT_RST = 16;
	localparam int LIM_RST  = 8;
	localparam int LOAD_RST = 256;

	localparam logic [CIDX_W-1:0] CFG_INIT  = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_LIMIT = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_LOAD  = 2'd2;

	typedef enum logic [0:0] {
		OP_INSERT = 1'b0,
		OP_LOOKUP = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_PRESENT  = 3'd1,
		ST_FOUND    = 3'd2,
		ST_ABSENT   = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef struct packed {
		opcode_t           opcode;
		logic [KEY_W-1:0]  key;
	} in_word_t;

	typedef struct packed {
		status_t           status;
		logic [BOUT_W-1:0] buckets_now;
		logic [TOT_W-1:0]  element_total;
	} out_word_t;

	// sequencer to datapath
	typedef struct packed {
		logic    load_item;
		logic    div_item;
		logic    set_h;
		logic    fill_rd;
		logic    fill_get;
		logic    scan_rd;
		logic    put_key;
		logic    st_we;
		status_t st_code;
		logic    g_init;
		logic    g_frd;
		logic    g_fget;
		logic    g_rd;
		logic    g_kst;
		logic    g_place;
		logic    g_wf_lo;
		logic    g_wf_hi;
		logic    g_next;
		logic    g_finish;
	} dp_cmd_t;

	// datapath to sequencer
	typedef struct packed {
		logic div_done;
		logic scan_end;
		logic hit;
		logic is_lookup;
		logic full;
		logic can_double;
		logic load_over;
		logic g_bucket_end;
		logic g_last;
	} dp_sts_t;

endpackage

@@ src/bihs_ram.sv @@
// ----------------------------------------------------------------------------
// bihs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bihs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/bihs_div.sv @@
// ----------------------------------------------------------------------------
// bihs_div
// Restoring remainder unit: key modulo bucket count, one bit per cycle.
// ----------------------------------------------------------------------------
module bihs_div import bihs_pkg::*; #(
	parameter int NBW = 9,
	parameter int HW  = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] dividend,
	input  logic [NBW-1:0]   divisor,
	output logic             done,
	output logic [HW-1:0]    rem
);

	logic [NBW:0]        r_q;
	logic [KEY_W-1:0]    dvd_q;
	logic [NBW-1:0]      dsr_q;
	logic [DCNT_W-1:0]   cnt_q;
	logic                run_q;
	logic                done_q;
	logic [NBW:0]        trial;
	logic [NBW:0]        diff;

	assign trial = {r_q[NBW-1:0], dvd_q[KEY_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(KEY_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (run_q) begin
			r_q   <= (trial >= {1'b0, dsr_q}) ? diff : trial;
			dvd_q <= {dvd_q[KEY_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign rem  = r_q[HW-1:0];

endmodule

@@ src/bihs_dp.sv @@
// ----------------------------------------------------------------------------
// bihs_dp
// Datapath: configuration, key and fill memories, remainder unit, counters.
// ----------------------------------------------------------------------------
module bihs_dp import bihs_pkg::*; #(
	parameter int MAX_BUCKETS  = 256,
	parameter int BUCKET_SLOTS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]  cfg_data,
	input  in_word_t          request,
	input  dp_cmd_t           cmd,
	output dp_sts_t           sts,
	output out_word_t         result
);

	localparam int NBW    = $clog2(MAX_BUCKETS + 1);
	localparam int HW     = $clog2(MAX_BUCKETS);
	localparam int FW     = $clog2(BUCKET_SLOTS + 1);
	localparam int DEPTH  = MAX_BUCKETS * BUCKET_SLOTS;
	localparam int AW     = $clog2(DEPTH);
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int NB_RST = (INIT_RST > MAX_BUCKETS) ? MAX_BUCKETS : INIT_RST;

	logic [INIT_W-1:0]  init_q;
	logic [LIM_W-1:0]   lim_q;
	logic [LOAD_W-1:0]  ml_q;
	logic [NBW-1:0]     nb_q;
	logic [CW-1:0]      cnt_q;
	logic [MAX_BUCKETS-1:0] vld_q;
	logic               vld_rd_q;
	status_t            status_q;

	logic [KEY_W-1:0]   key_q;
	opcode_t            op_q;
	logic [HW-1:0]      h_q;
	logic [FW-1:0]      fill_q;
	logic [FW-1:0]      slot_q;
	logic [HW-1:0]      gb_q;
	logic [FW-1:0]      gfill_q;
	logic [FW-1:0]      gs_q;
	logic [FW-1:0]      keep_q;
	logic [FW-1:0]      mov_q;
	logic [KEY_W-1:0]   gk_q;

	logic [31:0]        iv;
	logic [NBW-1:0]     nb_new;
	logic [31:0]        lv;
	logic [FW-1:0]      lim_eff;
	logic [HW-1:0]      hi_bucket;
	logic [AW-1:0]      scan_addr;
	logic [AW-1:0]      put_addr;
	logic [AW-1:0]      grd_addr;
	logic [AW-1:0]      lo_addr;
	logic [AW-1:0]      hi_addr;
	logic               stay;

	logic               st_we;
	logic [AW-1:0]      st_waddr;
	logic [KEY_W-1:0]   st_wdata;
	logic               st_re;
	logic [AW-1:0]      st_raddr;
	logic [KEY_W-1:0]   st_rdata;

	logic               fl_we;
	logic [HW-1:0]      fl_waddr;
	logic [FW-1:0]      fl_wdata;
	logic               fl_re;
	logic [HW-1:0]      fl_raddr;
	logic [FW-1:0]      fl_rdata;
	logic [FW-1:0]      fill_now;

	logic               div_start;
	logic [KEY_W-1:0]   div_dvd;
	logic [NBW-1:0]     div_dsr;
	logic               div_done;
	logic [HW-1:0]      div_rem;

	logic [31:0]        load_lhs;
	logic [31:0]        load_rhs;

	// clamp the configured counts into their legal ranges
	always_comb begin
		iv = 32'(init_q);
		if (cfg_we && cfg_idx == CFG_INIT) begin
			iv = 32'(cfg_data[INIT_W-1:0]);
		end
		if (iv == 32'd0) begin
			nb_new = NBW'(1);
		end else if (iv > 32'(MAX_BUCKETS)) begin
			nb_new = NBW'(MAX_BUCKETS);
		end else begin
			nb_new = iv[NBW-1:0];
		end
		lv = 32'(lim_q);
		if (lv == 32'd0) begin
			lim_eff = FW'(1);
		end else if (lv > 32'(BUCKET_SLOTS)) begin
			lim_eff = FW'(BUCKET_SLOTS);
		end else begin
			lim_eff = lv[FW-1:0];
		end
	end

	assign hi_bucket = HW'(32'(gb_q) + 32'(nb_q));
	assign scan_addr = AW'(32'(h_q) * BUCKET_SLOTS + 32'(slot_q));
	assign put_addr  = AW'(32'(h_q) * BUCKET_SLOTS + 32'(fill_q));
	assign grd_addr  = AW'(32'(gb_q) * BUCKET_SLOTS + 32'(gs_q));
	assign lo_addr   = AW'(32'(gb_q) * BUCKET_SLOTS + 32'(keep_q));
	assign hi_addr   = AW'(32'(hi_bucket) * BUCKET_SLOTS + 32'(mov_q));
	assign stay      = (div_rem == gb_q);

	assign st_we    = cmd.put_key | cmd.g_place;
	assign st_waddr = cmd.put_key ? put_addr : (stay ? lo_addr : hi_addr);
	assign st_wdata = cmd.put_key ? key_q : gk_q;
	assign st_re    = cmd.scan_rd | cmd.g_rd;
	assign st_raddr = cmd.scan_rd ? scan_addr : grd_addr;

	assign fl_we    = cmd.put_key | cmd.g_wf_lo | cmd.g_wf_hi;
	assign fl_waddr = cmd.put_key ? h_q : (cmd.g_wf_lo ? gb_q : hi_bucket);
	assign fl_wdata = cmd.put_key ? fill_q + 1'b1 : (cmd.g_wf_lo ? keep_q : mov_q);
	assign fl_re    = cmd.fill_rd | cmd.g_frd;
	assign fl_raddr = cmd.fill_rd ? div_rem : gb_q;
	assign fill_now = vld_rd_q ? fl_rdata : '0;

	assign div_start = cmd.div_item | cmd.g_kst;
	assign div_dvd   = cmd.g_kst ? st_rdata : key_q;
	assign div_dsr   = cmd.g_kst ? {nb_q[NBW-2:0], 1'b0} : nb_q;

	bihs_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	bihs_ram #(.WIDTH(FW), .DEPTH(MAX_BUCKETS)) u_fill (
		.clk   (clk),
		.we    (fl_we),
		.waddr (fl_waddr),
		.wdata (fl_wdata),
		.re    (fl_re),
		.raddr (fl_raddr),
		.rdata (fl_rdata)
	);

	bihs_div #(.NBW(NBW), .HW(HW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.rem      (div_rem)
	);

	// control state: configuration, set size, fill valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q   <= INIT_W'(INIT_RST);
			lim_q    <= LIM_W'(LIM_RST);
			ml_q     <= LOAD_W'(LOAD_RST);
			nb_q     <= NBW'(NB_RST);
			cnt_q    <= '0;
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
			status_q <= ST_INSERTED;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_INIT: begin
						init_q <= cfg_data[INIT_W-1:0];
						nb_q   <= nb_new;
						cnt_q  <= '0;
						vld_q  <= '0;
					end
					CFG_LIMIT: lim_q <= cfg_data[LIM_W-1:0];
					CFG_LOAD:  ml_q  <= cfg_data;
					default: ;
				endcase
			end else begin
				if (fl_we) begin
					vld_q[fl_waddr] <= 1'b1;
				end
				if (cmd.put_key) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (cmd.g_finish) begin
					nb_q <= {nb_q[NBW-2:0], 1'b0};
				end
			end
			if (fl_re) begin
				vld_rd_q <= vld_q[fl_raddr];
			end
			if (cmd.st_we) begin
				status_q <= cmd.st_code;
			end
		end
	end

	// working registers of the current item and of a rehash pass
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			key_q <= request.key;
			op_q  <= request.opcode;
		end
		if (cmd.set_h) begin
			h_q <= div_rem;
		end
		if (cmd.fill_get) begin
			fill_q <= fill_now;
			slot_q <= '0;
		end
		if (cmd.scan_rd) begin
			slot_q <= slot_q + 1'b1;
		end
		if (cmd.g_init) begin
			gb_q <= '0;
		end
		if (cmd.g_next) begin
			gb_q <= gb_q + 1'b1;
		end
		if (cmd.g_fget) begin
			gfill_q <= fill_now;
			gs_q    <= '0;
			keep_q  <= '0;
			mov_q   <= '0;
		end
		if (cmd.g_rd) begin
			gs_q <= gs_q + 1'b1;
		end
		if (cmd.g_kst) begin
			gk_q <= st_rdata;
		end
		if (cmd.g_place) begin
			if (stay) begin
				keep_q <= keep_q + 1'b1;
			end else begin
				mov_q <= mov_q + 1'b1;
			end
		end
	end

	assign load_lhs = 32'(cnt_q) << 8;
	assign load_rhs = 32'(ml_q) * 32'(nb_q);

	assign sts.div_done     = div_done;
	assign sts.scan_end     = (slot_q == fill_q);
	assign sts.hit          = (st_rdata == key_q);
	assign sts.is_lookup    = (op_q == OP_LOOKUP);
	assign sts.full         = (fill_q >= lim_eff);
	assign sts.can_double   = (32'(nb_q) * 2 <= 32'(MAX_BUCKETS));
	assign sts.load_over    = (load_lhs >= load_rhs);
	assign sts.g_bucket_end = (gs_q == gfill_q);
	assign sts.g_last       = (32'(gb_q) + 32'd1 == 32'(nb_q));

	assign result.status        = status_q;
	assign result.buckets_now   = BOUT_W'(32'(nb_q));
	assign result.element_total = TOT_W'(32'(cnt_q));

endmodule

@@ src/bihs_ctrl.sv @@
// ----------------------------------------------------------------------------
// bihs_ctrl
// Sequencer: walks one item through hash, scan, insert and rehash passes.
// ----------------------------------------------------------------------------
module bihs_ctrl import bihs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  dp_sts_t sts,
	output dp_cmd_t cmd,
	output logic    busy,
	output logic    done
);

	typedef enum logic [4:0] {
		S_IDLE, S_DSTART, S_DWAIT, S_FGET, S_SCAN, S_SCMP, S_CHK, S_LOAD,
		S_GINIT, S_GFRD, S_GFGET, S_GRD, S_GKST, S_GDIV, S_GWLO, S_GWHI, S_DONE
	} state_t;

	state_t state_q;
	state_t nxt;
	logic   ret_load_q;
	logic   ret_load_d;
	logic   busy_q;
	logic   done_q;

	always_comb begin
		nxt        = state_q;
		ret_load_d = ret_load_q;
		cmd        = '0;
		cmd.st_code = ST_INSERTED;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load_item = 1'b1;
					nxt = S_DSTART;
				end
			end
			S_DSTART: begin
				cmd.div_item = 1'b1;
				nxt = S_DWAIT;
			end
			S_DWAIT: begin
				if (sts.div_done) begin
					cmd.set_h   = 1'b1;
					cmd.fill_rd = 1'b1;
					nxt = S_FGET;
				end
			end
			S_FGET: begin
				cmd.fill_get = 1'b1;
				nxt = S_SCAN;
			end
			S_SCAN: begin
				if (sts.scan_end) begin
					if (sts.is_lookup) begin
						cmd.st_we   = 1'b1;
						cmd.st_code = ST_ABSENT;
						nxt = S_DONE;
					end else begin
						nxt = S_CHK;
					end
				end else begin
					cmd.scan_rd = 1'b1;
					nxt = S_SCMP;
				end
			end
			S_SCMP: begin
				if (sts.hit) begin
					cmd.st_we   = 1'b1;
					cmd.st_code = sts.is_lookup ? ST_FOUND : ST_PRESENT;
					nxt = S_DONE;
				end else begin
					nxt = S_SCAN;
				end
			end
			S_CHK: begin
				if (!sts.full) begin
					cmd.put_key = 1'b1;
					nxt = S_LOAD;
				end else if (sts.can_double) begin
					ret_load_d = 1'b0;
					nxt = S_GINIT;
				end else begin
					cmd.st_we   = 1'b1;
					cmd.st_code = ST_FULL;
					nxt = S_DONE;
				end
			end
			S_LOAD: begin
				if (sts.load_over && sts.can_double) begin
					ret_load_d = 1'b1;
					nxt = S_GINIT;
				end else begin
					cmd.st_we   = 1'b1;
					cmd.st_code = ST_INSERTED;
					nxt = S_DONE;
				end
			end
			S_GINIT: begin
				cmd.g_init = 1'b1;
				nxt = S_GFRD;
			end
			S_GFRD: begin
				cmd.g_frd = 1'b1;
				nxt = S_GFGET;
			end
			S_GFGET: begin
				cmd.g_fget = 1'b1;
				nxt = S_GRD;
			end
			S_GRD: begin
				if (sts.g_bucket_end) begin
					nxt = S_GWLO;
				end else begin
					cmd.g_rd = 1'b1;
					nxt = S_GKST;
				end
			end
			S_GKST: begin
				cmd.g_kst = 1'b1;
				nxt = S_GDIV;
			end
			S_GDIV: begin
				if (sts.div_done) begin
					cmd.g_place = 1'b1;
					nxt = S_GRD;
				end
			end
			S_GWLO: begin
				cmd.g_wf_lo = 1'b1;
				nxt = S_GWHI;
			end
			S_GWHI: begin
				cmd.g_wf_hi = 1'b1;
				if (sts.g_last) begin
					cmd.g_finish = 1'b1;
					nxt = ret_load_q ? S_LOAD : S_DSTART;
				end else begin
					cmd.g_next = 1'b1;
					nxt = S_GFRD;
				end
			end
			S_DONE: begin
				nxt = S_IDLE;
			end
			default: begin
				nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ret_load_q <= 1'b0;
			busy_q     <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= nxt;
			ret_load_q <= ret_load_d;
			busy_q     <= (nxt != S_IDLE);
			done_q     <= (nxt == S_DONE);
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

@@ src/bucketed_int_hash_set.sv @@
// ----------------------------------------------------------------------------
// bucketed_int_hash_set
// Set of 31-bit keys in fixed-length buckets with doubling and rehash.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive request (opcode, key) and raise start; the word is
//   taken at the clock edge where start is high and busy is low. busy stays
//   high until the result has been shown.
//   Result channel: done pulses for exactly one cycle with result (status,
//   buckets_now, element_total). The receiver must take it then; it cannot
//   stall the block.
//   Sequence: the bucket index comes from a one-bit-per-cycle remainder unit
//   that is started and waited on for its 31 steps, then the bucket is read
//   and compared slot by slot, a hit ending the scan. The next word is taken
//   no earlier than the cycle after done. Each doubling walks every old bucket
//   and moves each key to its low or high bucket; after a doubling forced by
//   a full bucket the key is hashed and scanned again.
//   Configuration: cfg_we, cfg_idx and cfg_data write a register at once;
//   the user must write only while busy is low, unchecked by the block.
//   Writing initial_buckets empties the set.
//   Reset: arst_n clears the set, loads 16 buckets, limit 8 and load 1.0.
// ----------------------------------------------------------------------------
`include "bucketed_int_hash_set_assert.svh"

module bucketed_int_hash_set import bihs_pkg::*; #(
	parameter int MAX_BUCKETS  = 256,
	parameter int BUCKET_SLOTS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  in_word_t          request,
	output logic              busy,
	output logic              done,
	output out_word_t         result,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]  cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencer: one item at a time, rehash passes run inside the item
	bihs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// datapath: memories, remainder unit, counters and result register
	bihs_dp #(
		.MAX_BUCKETS  (MAX_BUCKETS),
		.BUCKET_SLOTS (BUCKET_SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.request  (request),
		.cmd      (cmd),
		.sts      (sts),
		.result   (result)
	);

	// a result word is shown only while the item is still in flight
	`BIHS_ASSERT_SAME(a_done_in_item, done, busy)
	// drop busy right after the result word
	`BIHS_ASSERT_NEXT(a_idle_after_done, done, !busy)
	// an accepted command word holds the block busy
	`BIHS_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)

endmodule

@@ test/bucketed_int_hash_set_tb.sv @@
// ----------------------------------------------------------------------------
// bucketed_int_hash_set_tb
// Self-checking bench for the bucketed hash set: a queue-fed command driver,
// a result monitor and a built-in set model that predicts every result word.
// ----------------------------------------------------------------------------
module bucketed_int_hash_set_tb;
	import bihs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXB  = 256;
	localparam int SLOTS = 8;
	localparam logic [CIDX_W-1:0] CFG_NONE = 2'd3;   // unmapped index, ignored

	logic              clk;
	logic              arst_n;
	logic              start;
	in_word_t          request;
	logic              busy;
	logic              done;
	out_word_t         result;
	logic              cfg_we;
	logic [CIDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]  cfg_data;

	bucketed_int_hash_set #(.MAX_BUCKETS(MAXB), .BUCKET_SLOTS(SLOTS)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .request(request), .busy(busy),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	// ------------------------------------------------------------------------
	// Set model: key slots, bucket fills, bucket count, element count, regs
	// ------------------------------------------------------------------------
	logic [KEY_W-1:0] slot_key [MAXB*SLOTS];
	int               fill_of  [MAXB];
	int               nbuckets;
	int               nstored;
	int               r_init, r_limit, r_load;

	in_word_t  pending_q[$];     // command words waiting for the driver
	out_word_t want_q[$];        // predicted result words, oldest first
	logic [KEY_W-1:0] key_pool[$];

	int  fails;
	int  status_seen [5];
	bit  hold_off;
	bit  no_gaps;
	int  gap_left;
	int  collide_lo;

	function automatic int clamp_count(int v);
		if (v < 1) return 1;
		if (v > MAXB) return MAXB;
		return v;
	endfunction

	function automatic int eff_limit();
		if (r_limit < 1) return 1;
		if (r_limit > SLOTS) return SLOTS;
		return r_limit;
	endfunction

	function automatic void empty_set();
		foreach (slot_key[i]) slot_key[i] = '0;
		foreach (fill_of[i]) fill_of[i] = 0;
		nstored  = 0;
		nbuckets = clamp_count(r_init);
	endfunction

	function automatic bit may_double();
		return nbuckets * 2 <= MAXB;
	endfunction

	// Double the bucket count and spread every key over the new table.
	function automatic void double_table();
		logic [KEY_W-1:0] old_key [MAXB*SLOTS];
		int old_fill [MAXB];
		int old_n, new_n, f, h;
		old_key  = slot_key;
		old_fill = fill_of;
		old_n    = nbuckets;
		new_n    = nbuckets * 2;
		foreach (fill_of[i]) fill_of[i] = 0;
		for (int b = 0; b < old_n; b++) begin
			f = (old_fill[b] > SLOTS) ? SLOTS : old_fill[b];
			for (int s = 0; s < f; s++) begin
				h = int'(longint'(old_key[b*SLOTS+s]) % new_n);
				if (fill_of[h] < SLOTS) begin
					slot_key[h*SLOTS+fill_of[h]] = old_key[b*SLOTS+s];
					fill_of[h]++;
				end
			end
		end
		nbuckets = new_n;
	endfunction

	function automatic bit holds_key(logic [KEY_W-1:0] k, int h);
		int f;
		f = (fill_of[h] > SLOTS) ? SLOTS : fill_of[h];
		for (int s = 0; s < f; s++)
			if (slot_key[h*SLOTS+s] == k) return 1'b1;
		return 1'b0;
	endfunction

	function automatic out_word_t apply_word(in_word_t w);
		out_word_t o;
		status_t   st;
		int        h, lim;
		h = int'(longint'(w.key) % nbuckets);
		if (w.opcode == OP_LOOKUP) begin
			st = holds_key(w.key, h) ? ST_FOUND : ST_ABSENT;
		end else if (holds_key(w.key, h)) begin
			st = ST_PRESENT;
		end else begin
			lim = eff_limit();
			while (fill_of[h] >= lim && may_double()) begin
				double_table();
				h = int'(longint'(w.key) % nbuckets);
			end
			if (fill_of[h] >= lim) begin
				st = ST_FULL;
			end else begin
				slot_key[h*SLOTS+fill_of[h]] = w.key;
				fill_of[h]++;
				nstored++;
				st = ST_INSERTED;
				while (nstored * 256 >= r_load * nbuckets && may_double())
					double_table();
			end
		end
		o.status        = st;
		o.buckets_now   = BOUT_W'(nbuckets);
		o.element_total = TOT_W'(nstored);
		return o;
	endfunction

	function automatic void apply_cfg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] v);
		case (idx)
			CFG_INIT: begin
				r_init = int'(v & 12'h1FF);
				empty_set();
			end
			CFG_LIMIT: r_limit = int'(v & 12'hF);
			CFG_LOAD:  r_load  = int'(v);
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Clock, reset and run limit
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("Simulation FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Driver: pop command words, hold start until the block takes one,
	// then wait a random gap before offering the next word
	// ------------------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 15);
		return $urandom_range(30, 120);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic go;
		if (!arst_n) begin
			start    <= 1'b0;
			request  <= '0;
			gap_left <= 0;
		end else begin
			go = start;
			// the word is taken on this edge: predict it now
			if (start && !busy) begin
				want_q.push_back(apply_word(request));
				go = 1'b0;
			end
			if (!go) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (pending_q.size() > 0 && !hold_off) begin
					request  <= pending_q.pop_front();
					go = 1'b1;
					gap_left <= pick_gap();
				end
			end
			start <= go;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: every done pulse is checked against the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		out_word_t exp_w;
		if (arst_n && done) begin
			if (want_q.size() == 0) begin
				$error("result word with no prediction waiting: %p", result);
				fails++;
			end else begin
				exp_w = want_q.pop_front();
				if (result.status !== exp_w.status) begin
					$error("status: expected %0d, actual %0d", exp_w.status, result.status);
					fails++;
				end
				if (result.buckets_now !== exp_w.buckets_now) begin
					$error("buckets_now: expected %0d, actual %0d",
						exp_w.buckets_now, result.buckets_now);
					fails++;
				end
				if (result.element_total !== exp_w.element_total) begin
					$error("element_total: expected %0d, actual %0d",
						exp_w.element_total, result.element_total);
					fails++;
				end
				if (int'(exp_w.status) < 5) status_seen[int'(exp_w.status)]++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	task automatic wait_idle();
		do @(posedge clk);
		while (pending_q.size() != 0 || start || want_q.size() != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= v;
		@(posedge clk);
		apply_cfg(idx, v);
		cfg_we   <= 1'b0;
	endtask

	task automatic queue_word(opcode_t op, logic [KEY_W-1:0] k);
		in_word_t w;
		w.opcode = op;
		w.key    = k;
		pending_q.push_back(w);
		if (op == OP_INSERT) begin
			key_pool.push_back(k);
			if (key_pool.size() > 64) void'(key_pool.pop_front());
		end
	endtask

	// Keys mix wide random values, repeats, small values, the extremes and
	// keys that share one bucket at power-of-two table sizes (same low byte).
	function automatic logic [KEY_W-1:0] pick_key(bit reuse_ok);
		int r;
		r = $urandom_range(0, 99);
		if (reuse_ok && key_pool.size() > 0 && r < 35)
			return key_pool[$urandom_range(0, key_pool.size()-1)];
		if (r < 55) return KEY_W'($urandom);
		if (r < 75) return KEY_W'($urandom_range(0, 63));
		if (r < 92) return KEY_W'(($urandom_range(0, 24'hFFFFFF) << 8) | collide_lo);
		return ($urandom_range(0, 1) == 1) ? {KEY_W{1'b1}} : '0;
	endfunction

	task automatic run_phase(int init, int lim, int load, int n, bit fast, bit squeeze);
		wait_idle();
		cfg_write(CFG_LIMIT, CFG_W'(lim));
		cfg_write(CFG_LOAD, CFG_W'(load));
		cfg_write(CFG_NONE, CFG_W'($urandom));
		cfg_write(CFG_INIT, CFG_W'(init));
		key_pool.delete();
		collide_lo = $urandom_range(0, 255);
		no_gaps    = fast;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 55) queue_word(OP_INSERT, pick_key(1'b1));
			else queue_word(OP_LOOKUP, pick_key(1'b1));
		end
		if (squeeze) begin
			// stop feeding halfway and let the block drain completely
			while (pending_q.size() > n / 2) @(posedge clk);
			hold_off = 1'b1;
			while (want_q.size() != 0 || busy || start) @(posedge clk);
			hold_off = 1'b0;
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_idx    = '0;
		cfg_data   = '0;
		fails      = 0;
		hold_off   = 1'b0;
		no_gaps    = 1'b0;
		collide_lo = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
		r_init  = INIT_RST;
		r_limit = LIM_RST;
		r_load  = LOAD_RST;
		empty_set();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on the reset settings: extremes, duplicates, misses,
		// then nine keys of one bucket so growth hits the ceiling and drops.
		queue_word(OP_LOOKUP, '0);
		queue_word(OP_INSERT, '0);
		queue_word(OP_INSERT, {KEY_W{1'b1}});
		queue_word(OP_LOOKUP, {KEY_W{1'b1}});
		queue_word(OP_LOOKUP, '0);
		queue_word(OP_INSERT, '0);
		queue_word(OP_LOOKUP, KEY_W'(5));
		for (int i = 1; i <= 9; i++) queue_word(OP_INSERT, KEY_W'(i * 256));
		queue_word(OP_LOOKUP, KEY_W'(9 * 256));
		queue_word(OP_LOOKUP, KEY_W'(8 * 256));
		queue_word(OP_INSERT, KEY_W'(31'h2AAA_AAAA));
		queue_word(OP_INSERT, KEY_W'(31'h5555_5555));

		// Random phases across settings, extremes and clamped values among them
		run_phase(1,   1,  1,    130, 1'b0, 1'b0);
		run_phase(256, 8,  4095, 140, 1'b0, 1'b1);
		run_phase(0,   0,  0,    200, 1'b0, 1'b0);
		run_phase(12'hFFF, 15, 4095, 130, 1'b1, 1'b0);
		run_phase(16,  4,  384,  140, 1'b1, 1'b0);
		run_phase(2,   2,  128,  140, 1'b0, 1'b0);
		run_phase(5,   3,  700,  140, 1'b0, 1'b1);
		run_phase(100, 8,  256,  130, 1'b0, 1'b0);
		run_phase(3,   1,  2000, 130, 1'b0, 1'b0);

		wait_idle();
		repeat (100) @(posedge clk);
		$display("Covered inserted %0d, duplicate %0d, found %0d, missed %0d, dropped %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
		$display("over ten register settings including clamped and boundary values");
		if (fails == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
